FILE: rtl/core/hbg_pkg.sv
// ----------------------------------------------------------------------------
// hbg_pkg
// Types and constants shared by the hybrid bimodal/gshare predictor.
// ----------------------------------------------------------------------------
package hbg_pkg;

  localparam int PcWidth = 32;

  localparam logic FuncFetch  = 1'b0;
  localparam logic FuncRetire = 1'b1;

  typedef logic signed [1:0] ctr_t;

  localparam ctr_t CtrMin = 2'sb10;
  localparam ctr_t CtrMax = 2'sb01;

  typedef struct packed {
    logic               func;
    logic [PcWidth-1:0] pc;
    logic               is_conditional;
    logic               is_branch;
    logic               taken;
  } req_t;

  typedef struct packed {
    logic prediction_valid;
    logic predicted_taken;
    logic chose_bimodal;
  } rsp_t;

  // Write-back of one event to the three tables.
  typedef struct packed {
    logic ch_we;
    ctr_t ch_wd;
    logic bi_we;
    logic bi_wd;
    logic g_we;
    ctr_t g_wd;
  } upd_t;

endpackage

FILE: rtl/core/hbg_if.sv
// ----------------------------------------------------------------------------
// hbg_if
// Valid/ready channels of the predictor: event beats in, result beats out.
// ----------------------------------------------------------------------------
interface hbg_req_if;
  logic          valid;
  logic          ready;
  hbg_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hbg_rsp_if;
  logic          valid;
  logic          ready;
  hbg_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/hybrid_bimodal_gshare_predictor.sv
// ----------------------------------------------------------------------------
// hybrid_bimodal_gshare_predictor
// Tournament predictor: bimodal bits, gshare counters and a chooser table.
// ----------------------------------------------------------------------------
// Channels: req_i carries one branch event per beat (func selects fetch
// predict or retire train); rsp_o returns exactly one result beat per event,
// in order. Fetch events on conditional branches report the prediction and
// the component chosen; every other event returns an all-zero result.
// Flow: an accepted event has its table reads registered, and its result is
// registered onto rsp_o as the event leaves the execute state. No new event
// is taken until then, since the tables are read, modified and written back
// through their registered reads. Reset: histories clear at once; then a
// clearing pass over 2^max(index bits) addresses zeroes all three tables,
// during which req_i is held not ready.
// Stall: a result waiting on rsp_o does not block the next event from being
// accepted; that event holds in the execute cycle until the result register
// frees, and its table write-back happens only then.
// ----------------------------------------------------------------------------
module hybrid_bimodal_gshare_predictor #(
  parameter int GSHARE_INDEX_BITS  = 18,
  parameter int BIMODAL_INDEX_BITS = 19,
  parameter int CHOOSER_INDEX_BITS = 18
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  hbg_req_if.sink  req_i,
  hbg_rsp_if.source rsp_o
);

  localparam int GB = GSHARE_INDEX_BITS;
  localparam int BB = BIMODAL_INDEX_BITS;
  localparam int CB = CHOOSER_INDEX_BITS;
  localparam int MaxGb   = (GB > BB) ? GB : BB;
  localparam int ClrBits = (MaxGb > CB) ? MaxGb : CB;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ClrBits-1:0] clr_q, clr_d;
  logic [GB-1:0]      fhist_q, fhist_d;
  logic [GB-1:0]      rhist_q, rhist_d;

  logic          func_q, cond_q, taken_q;
  logic [GB-1:0] g_idx_q;
  logic [BB-1:0] b_idx_q;
  logic [CB-1:0] c_idx_q;

  logic          out_valid_q, out_valid_d;
  hbg_pkg::rsp_t out_data_q;

  logic          accept;
  logic          done;
  logic          clearing;
  logic [GB-1:0] hist_sel;
  logic [GB-1:0] hist_next;
  logic [GB-1:0] g_idx;

  hbg_pkg::ctr_t ch_rd, g_rd;
  logic          bi_rd;
  hbg_pkg::rsp_t rsp;
  hbg_pkg::upd_t upd;

  logic          ch_we, bi_we, g_we;
  logic [CB-1:0] ch_wa;
  logic [BB-1:0] bi_wa;
  logic [GB-1:0] g_wa;
  hbg_pkg::ctr_t ch_wd, g_wd;
  logic          bi_wd;

  assign clearing = (state_q == ST_CLEAR);
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept = req_i.valid && req_i.ready;
  assign done = (state_q == ST_EXEC) && (!out_valid_q || rsp_o.ready);

  // History of the side the event belongs to.
  assign hist_sel = (req_i.payload.func == hbg_pkg::FuncRetire) ? rhist_q : fhist_q;
  assign g_idx    = hist_sel ^ req_i.payload.pc[GB-1:0];

  always_comb begin
    hist_next = hist_sel;
    if (req_i.payload.is_conditional) begin
      hist_next = {hist_sel[GB-2:0], req_i.payload.taken};
    end else if (req_i.payload.is_branch) begin
      hist_next = {hist_sel[GB-2:0], 1'b1};
    end
  end

  always_comb begin
    fhist_d = fhist_q;
    rhist_d = rhist_q;
    if (accept) begin
      if (req_i.payload.func == hbg_pkg::FuncRetire) begin
        rhist_d = hist_next;
      end else begin
        fhist_d = hist_next;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      fhist_q     <= '0;
      rhist_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fhist_q     <= fhist_d;
      rhist_q     <= rhist_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= req_i.payload.func;
      cond_q  <= req_i.payload.is_conditional;
      taken_q <= req_i.payload.taken;
      g_idx_q <= g_idx;
      b_idx_q <= req_i.payload.pc[BB-1:0];
      c_idx_q <= req_i.payload.pc[CB-1:0];
    end
    if (done) begin
      out_data_q <= rsp;
    end
  end

  // Write ports: clearing sweep, else write-back of the finished event.
  always_comb begin
    if (clearing) begin
      ch_we = ((clr_q >> CB) == '0);
      bi_we = ((clr_q >> BB) == '0);
      g_we  = ((clr_q >> GB) == '0);
      ch_wa = clr_q[CB-1:0];
      bi_wa = clr_q[BB-1:0];
      g_wa  = clr_q[GB-1:0];
      ch_wd = '0;
      bi_wd = 1'b0;
      g_wd  = '0;
    end else begin
      ch_we = done && upd.ch_we;
      bi_we = done && upd.bi_we;
      g_we  = done && upd.g_we;
      ch_wa = c_idx_q;
      bi_wa = b_idx_q;
      g_wa  = g_idx_q;
      ch_wd = upd.ch_wd;
      bi_wd = upd.bi_wd;
      g_wd  = upd.g_wd;
    end
  end

  hbg_table #(
    .Width     (2),
    .AddrWidth (CB)
  ) u_chooser (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_wa),
    .wdata_i (ch_wd),
    .re_i    (accept),
    .raddr_i (req_i.payload.pc[CB-1:0]),
    .rdata_o (ch_rd)
  );

  hbg_table #(
    .Width     (1),
    .AddrWidth (BB)
  ) u_bimodal (
    .clk_i   (clk_i),
    .we_i    (bi_we),
    .waddr_i (bi_wa),
    .wdata_i (bi_wd),
    .re_i    (accept),
    .raddr_i (req_i.payload.pc[BB-1:0]),
    .rdata_o (bi_rd)
  );

  hbg_table #(
    .Width     (2),
    .AddrWidth (GB)
  ) u_gshare (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_wa),
    .wdata_i (g_wd),
    .re_i    (accept),
    .raddr_i (g_idx),
    .rdata_o (g_rd)
  );

  hbg_update u_update (
    .func_i  (func_q),
    .cond_i  (cond_q),
    .taken_i (taken_q),
    .ch_rd_i (ch_rd),
    .bi_rd_i (bi_rd),
    .g_rd_i  (g_rd),
    .rsp_o   (rsp),
    .upd_o   (upd)
  );

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_data_q;

endmodule

FILE: rtl/core/hbg_table.sv
// ----------------------------------------------------------------------------
// hbg_table
// Single-port-write, single-port-read table with a registered read.
// ----------------------------------------------------------------------------
module hbg_table #(
  parameter int Width     = 2,
  parameter int AddrWidth = 18
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  localparam int Depth = 1 << AddrWidth;

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/hbg_update.sv
// ----------------------------------------------------------------------------
// hbg_update
// Prediction and training of one event from the table read data.
// ----------------------------------------------------------------------------
module hbg_update (
  input  logic          func_i,
  input  logic          cond_i,
  input  logic          taken_i,
  input  hbg_pkg::ctr_t ch_rd_i,
  input  logic          bi_rd_i,
  input  hbg_pkg::ctr_t g_rd_i,
  output hbg_pkg::rsp_t rsp_o,
  output hbg_pkg::upd_t upd_o
);

  logic use_bi;
  logic g_pred;
  logic bi_ok;
  logic g_ok;
  logic fetch_cond;
  logic retire_cond;

  assign use_bi      = ~ch_rd_i[1];
  assign g_pred      = ~g_rd_i[1];
  assign bi_ok       = (bi_rd_i == taken_i);
  assign g_ok        = (g_pred == taken_i);
  assign fetch_cond  = cond_i && (func_i == hbg_pkg::FuncFetch);
  assign retire_cond = cond_i && (func_i == hbg_pkg::FuncRetire);

  always_comb begin
    rsp_o.prediction_valid = fetch_cond;
    rsp_o.predicted_taken  = fetch_cond && (use_bi ? bi_rd_i : g_pred);
    rsp_o.chose_bimodal    = fetch_cond && use_bi;
  end

  always_comb begin
    upd_o.ch_we = retire_cond;
    upd_o.ch_wd = ch_rd_i;
    if (bi_ok && !g_ok && (ch_rd_i != hbg_pkg::CtrMax)) begin
      upd_o.ch_wd = ch_rd_i + 2'sd1;
    end else if (!bi_ok && g_ok && (ch_rd_i != hbg_pkg::CtrMin)) begin
      upd_o.ch_wd = ch_rd_i - 2'sd1;
    end

    upd_o.bi_we = retire_cond && use_bi;
    upd_o.bi_wd = taken_i;

    upd_o.g_we = retire_cond && !use_bi;
    upd_o.g_wd = g_rd_i;
    if (taken_i) begin
      if (g_rd_i != hbg_pkg::CtrMax) begin
        upd_o.g_wd = g_rd_i + 2'sd1;
      end
    end else begin
      if (g_rd_i != hbg_pkg::CtrMin) begin
        upd_o.g_wd = g_rd_i - 2'sd1;
      end
    end
  end

endmodule

FILE: dv/hybrid_bimodal_gshare_predictor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_bimodal_gshare_predictor_checker
// Watches the event and result channels and keeps its own copy of the three
// tables and both histories. Each accepted event is run through that copy to
// give the result it should produce. Each accepted result beat is compared,
// field by field and in order, against the oldest result still outstanding.
// ----------------------------------------------------------------------------
module hybrid_bimodal_gshare_predictor_checker #(
  parameter int GSHARE_INDEX_BITS  = 18,
  parameter int BIMODAL_INDEX_BITS = 19,
  parameter int CHOOSER_INDEX_BITS = 18
) (
  input  logic clk_i,
  input  logic rst_ni,
  hbg_req_if   req_mon,
  hbg_rsp_if   rsp_mon,
  output int   mismatches_o,
  output int   pending_o
);

  typedef bit signed [1:0] sat_ctr_t;

  // Tables start cleared, as after the clearing pass.
  sat_ctr_t gshare_ctr  [1 << GSHARE_INDEX_BITS];
  bit       bimodal_bit [1 << BIMODAL_INDEX_BITS];
  sat_ctr_t chooser_ctr [1 << CHOOSER_INDEX_BITS];

  logic [GSHARE_INDEX_BITS-1:0] fetch_hist;
  logic [GSHARE_INDEX_BITS-1:0] retire_hist;
  hbg_pkg::rsp_t                expected_results [$];
  int                           err_count;

  function automatic logic [GSHARE_INDEX_BITS-1:0] shift_history(
      logic [GSHARE_INDEX_BITS-1:0] hist, hbg_pkg::req_t ev);
    if (ev.is_conditional) return {hist[GSHARE_INDEX_BITS-2:0], ev.taken};
    if (ev.is_branch) return {hist[GSHARE_INDEX_BITS-2:0], 1'b1};
    return hist;
  endfunction

  task automatic predict_branch_event(input hbg_pkg::req_t ev, output hbg_pkg::rsp_t res);
    logic [CHOOSER_INDEX_BITS-1:0] ci;
    logic [BIMODAL_INDEX_BITS-1:0] bi;
    logic [GSHARE_INDEX_BITS-1:0]  gi;
    logic                          use_bimodal;
    logic                          bimodal_right;
    logic                          gshare_right;
    ci          = ev.pc[CHOOSER_INDEX_BITS-1:0];
    bi          = ev.pc[BIMODAL_INDEX_BITS-1:0];
    use_bimodal = chooser_ctr[ci] >= 0;
    res         = '0;
    if (ev.func == hbg_pkg::FuncFetch) begin
      gi = fetch_hist ^ ev.pc[GSHARE_INDEX_BITS-1:0];
      if (ev.is_conditional) begin
        res.prediction_valid = 1'b1;
        res.chose_bimodal    = use_bimodal;
        res.predicted_taken  = use_bimodal ? bimodal_bit[bi] : (gshare_ctr[gi] >= 0);
      end
      fetch_hist = shift_history(fetch_hist, ev);
    end else begin
      gi = retire_hist ^ ev.pc[GSHARE_INDEX_BITS-1:0];
      if (ev.is_conditional) begin
        bimodal_right = bimodal_bit[bi] == ev.taken;
        gshare_right  = (gshare_ctr[gi] >= 0) == ev.taken;
        if (bimodal_right && !gshare_right && chooser_ctr[ci] < hbg_pkg::CtrMax) begin
          chooser_ctr[ci] = chooser_ctr[ci] + 2'sd1;
        end else if (!bimodal_right && gshare_right && chooser_ctr[ci] > hbg_pkg::CtrMin) begin
          chooser_ctr[ci] = chooser_ctr[ci] - 2'sd1;
        end
        // Train only the component that was chosen.
        if (use_bimodal) begin
          bimodal_bit[bi] = ev.taken;
        end else if (ev.taken) begin
          if (gshare_ctr[gi] < hbg_pkg::CtrMax) gshare_ctr[gi] = gshare_ctr[gi] + 2'sd1;
        end else begin
          if (gshare_ctr[gi] > hbg_pkg::CtrMin) gshare_ctr[gi] = gshare_ctr[gi] - 2'sd1;
        end
      end
      retire_hist = shift_history(retire_hist, ev);
    end
  endtask

  function automatic int check_field(string field, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hbg_pkg::rsp_t got;
    hbg_pkg::rsp_t want;
    hbg_pkg::rsp_t pred;
    if (!rst_ni) begin
      fetch_hist  = '0;
      retire_hist = '0;
      expected_results.delete();
      err_count = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.payload;
        if (expected_results.size() == 0) begin
          $error("result beat with no event outstanding: valid=%0b taken=%0b bimodal=%0b",
                 got.prediction_valid, got.predicted_taken, got.chose_bimodal);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          err_count += check_field("prediction_valid", want.prediction_valid,
                                   got.prediction_valid);
          err_count += check_field("predicted_taken", want.predicted_taken,
                                   got.predicted_taken);
          err_count += check_field("chose_bimodal", want.chose_bimodal, got.chose_bimodal);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_branch_event(req_mon.payload, pred);
        expected_results.push_back(pred);
      end
      mismatches_o <= err_count;
      pending_o    <= expected_results.size();
    end
  end

endmodule

FILE: dv/hybrid_bimodal_gshare_predictor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_bimodal_gshare_predictor_tb
// Drives branch events into the predictor and collects its result beats,
// with random gaps on the sender and random stalls on the receiver. A short
// directed run covers the extreme PCs, every event kind and the saturation
// corners; the random run mostly issues fetch-then-retire blocks over a small
// pool of branch addresses so that the tables train, with some noise mixed
// in. The checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module hybrid_bimodal_gshare_predictor_tb;

  localparam int GshareBits    = 18;
  localparam int BimodalBits   = 19;
  localparam int ChooserBits   = 18;
  localparam int PcHighBits    = 32 - BimodalBits;
  localparam int MaxIndexBits  = (GshareBits > BimodalBits) ?
                                 ((GshareBits > ChooserBits) ? GshareBits : ChooserBits) :
                                 ((BimodalBits > ChooserBits) ? BimodalBits : ChooserBits);
  localparam int WatchdogLimit = 4 * (1 << MaxIndexBits) + 1000;
  localparam int NumEvents     = 750;
  localparam int PoolSize      = 16;

  logic clk_i = 1'b0;
  logic rst_ni;

  hbg_req_if req_ch ();
  hbg_rsp_if rsp_ch ();

  int   pending_beats;
  int   mismatches;
  int   idle_cycles = 0;
  int   sent = 0;
  int   stall_left;
  int   sink_cycles = 0;
  bit   src_quiet = 1'b0;
  bit   sink_quiet = 1'b0;
  logic [31:0] pc_pool [PoolSize];
  bit          pool_bias [PoolSize];

  always #5 clk_i = ~clk_i;

  hybrid_bimodal_gshare_predictor #(
    .GSHARE_INDEX_BITS (GshareBits),
    .BIMODAL_INDEX_BITS(BimodalBits),
    .CHOOSER_INDEX_BITS(ChooserBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  hybrid_bimodal_gshare_predictor_checker #(
    .GSHARE_INDEX_BITS (GshareBits),
    .BIMODAL_INDEX_BITS(BimodalBits),
    .CHOOSER_INDEX_BITS(ChooserBits)
  ) predictor_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .mismatches_o(mismatches),
    .pending_o   (pending_beats)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic hbg_pkg::req_t make_event(logic func, logic [31:0] pc, logic cond,
                                               logic br, logic tk);
    hbg_pkg::req_t ev;
    ev.func           = func;
    ev.pc             = pc;
    ev.is_conditional = cond;
    ev.is_branch      = br;
    ev.taken          = tk;
    return ev;
  endfunction

  task automatic send_event(input hbg_pkg::req_t ev);
    int gap;
    if (sent % 64 == 0) src_quiet = ($urandom_range(0, 4) == 0);
    gap = src_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= ev;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left   <= sink_quiet ? 0 : pick_gap();
      end
      sink_cycles <= sink_cycles + 1;
      if (sink_cycles % 256 == 0) sink_quiet <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("hybrid_bimodal_gshare_predictor_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    hbg_pkg::req_t blk [8];
    hbg_pkg::req_t ev;
    int            n;
    int            slot;
    int            kind;
    int            start;
    bit            paused;
    logic          tk;
    logic [31:0]   pc;
    rst_ni         = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    paused         = 1'b0;
    // Pair up pool entries that share the chooser and gshare index but not the bimodal one.
    for (int i = 0; i < PoolSize; i++) begin
      pc_pool[i]   = (i % 2 == 1) ? (pc_pool[i-1] ^ (32'h1 << GshareBits)) : $urandom();
      pool_bias[i] = 1'($urandom_range(0, 1));
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(make_event(hbg_pkg::FuncFetch, 32'h0000_0000, 1'b1, 1'b0, 1'b0));
    send_event(make_event(hbg_pkg::FuncFetch, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    send_event(make_event(hbg_pkg::FuncFetch, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b1));
    send_event(make_event(hbg_pkg::FuncFetch, 32'h5555_5555, 1'b0, 1'b1, 1'b0));
    send_event(make_event(hbg_pkg::FuncRetire, 32'h0000_0000, 1'b0, 1'b0, 1'b1));
    send_event(make_event(hbg_pkg::FuncRetire, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1));
    drain_results();
    // Push one chooser entry to the top, then train the other way and back.
    repeat (3) send_event(make_event(hbg_pkg::FuncRetire, 32'h0001_2340, 1'b1, 1'b0, 1'b0));
    repeat (4) send_event(make_event(hbg_pkg::FuncRetire, 32'h0001_2340, 1'b1, 1'b0, 1'b1));
    send_event(make_event(hbg_pkg::FuncFetch, 32'h0001_2340, 1'b1, 1'b0, 1'b0));
    repeat (4) send_event(make_event(hbg_pkg::FuncRetire, 32'hFFFC_0008, 1'b1, 1'b1, 1'b1));
    repeat (3) send_event(make_event(hbg_pkg::FuncRetire, 32'hFFFC_0008, 1'b1, 1'b0, 1'b0));
    send_event(make_event(hbg_pkg::FuncFetch, 32'hFFFC_0008, 1'b1, 1'b0, 1'b1));
    send_event(make_event(hbg_pkg::FuncRetire, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    send_event(make_event(hbg_pkg::FuncFetch, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0));
    drain_results();

    start = sent;
    while (sent - start < NumEvents) begin
      if (!paused && sent - start >= NumEvents / 2) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          slot = $urandom_range(0, PoolSize - 1);
          kind = $urandom_range(0, 99);
          pc   = {PcHighBits'($urandom_range(0, (1 << PcHighBits) - 1)),
                  pc_pool[slot][BimodalBits-1:0]};
          tk   = ($urandom_range(0, 9) < 8) ? pool_bias[slot] : !pool_bias[slot];
          if (kind < 70) begin
            blk[i] = make_event(hbg_pkg::FuncFetch, pc, 1'b1, 1'($urandom_range(0, 1)), tk);
          end else if (kind < 85) begin
            blk[i] = make_event(hbg_pkg::FuncFetch, pc, 1'b0, 1'b1,
                                1'($urandom_range(0, 1)));
          end else begin
            blk[i] = make_event(hbg_pkg::FuncFetch, pc, 1'b0, 1'b0,
                                1'($urandom_range(0, 1)));
          end
          send_event(blk[i]);
        end
        for (int i = 0; i < n; i++) begin
          ev      = blk[i];
          ev.func = hbg_pkg::FuncRetire;
          send_event(ev);
        end
      end else begin
        send_event(make_event(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("hybrid_bimodal_gshare_predictor_tb: clean");
    end else begin
      $display("hybrid_bimodal_gshare_predictor_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/hbg_pkg.sv
rtl/core/hbg_if.sv
rtl/core/hbg_table.sv
rtl/core/hbg_update.sv
rtl/core/hybrid_bimodal_gshare_predictor.sv
dv/hybrid_bimodal_gshare_predictor_checker.sv
dv/hybrid_bimodal_gshare_predictor_tb.sv
